FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted insert priority queue
// Item structs for both channels, status codes and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int unsigned JOB_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 4;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic             command;
		logic [JOB_W-1:0] job_value;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [JOB_W-1:0]    removed_job;
		logic [OCC_W-1:0]    occupancy;
	} out_item_t;

	// broadcast control word for every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [JOB_W-1:0] job_value;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one job value, compares it with the broadcast value and takes its
// left neighbor, the new value, or its right neighbor as the queue changes.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire                   clk,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire                   occ,
	input  wire                   tail,
	input  wire                   left_gt,
	input  wire [spq_pkg::JOB_W-1:0] left_val,
	input  wire [spq_pkg::JOB_W-1:0] right_val,
	output logic                  gt,
	output logic [spq_pkg::JOB_W-1:0] val
);
	import spq_pkg::*;

	logic [JOB_W-1:0] val_q;

	// stored value strictly greater than the incoming one
	assign gt  = occ && (val_q > ctl.job_value);
	assign val = val_q;

	// insert shifts greater values back one slot, remove pulls all forward
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (gt || tail) begin
				val_q <= left_gt ? left_val : ctl.job_value;
			end
		end else if (ctl.rem) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

FILE: sv/sorted_insert_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top: bounded min-priority queue
// A row of cells keeps the jobs sorted, smallest first; equal values leave
// in arrival order. Inserts into a full queue and removes on an empty queue
// are reported by status and change nothing.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_ready  | in_item  (command, job_value)
//   out      | out_valid / out_ready| out_item (status, removed_job, occupancy)
//
// One item per cycle while in_ready is high: every cell compares against the new job at once and
// the whole row shifts in the cycle the item is accepted.
// The result appears in the output register in the cycle after acceptance.
// in_ready drops only while a result waits and out_ready is low.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue_top #(
	parameter int unsigned CAPACITY = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire spq_pkg::in_item_t in_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output spq_pkg::out_item_t   out_item
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	out_item_t        out_item_q;

	logic             accept;
	logic             is_full;
	logic             is_empty;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] count_next;
	logic [EXT_W-1:0] count_ext;

	logic             gt  [CAPACITY];
	logic [JOB_W-1:0] val [CAPACITY];

	// handshake
	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// command decode
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	always_comb begin
		ctl.ins       = accept && (in_item.command == CMD_INSERT) && !is_full;
		ctl.rem       = accept && (in_item.command == CMD_REMOVE) && !is_empty;
		ctl.job_value = in_item.job_value;
		count_next    = count_q;
		if (ctl.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign count_ext = EXT_W'(count_next);

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             c_left_gt;
		logic [JOB_W-1:0] c_left_val;
		logic [JOB_W-1:0] c_right_val;

		if (i == 0) begin : g_head
			assign c_left_gt  = 1'b0;
			assign c_left_val = '0;
		end else begin : g_body
			assign c_left_gt  = gt[i-1];
			assign c_left_val = val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign c_right_val = val[i];
		end else begin : g_mid
			assign c_right_val = val[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (CNT_W'(i) < count_q),
			.tail      (CNT_W'(i) == count_q),
			.left_gt   (c_left_gt),
			.left_val  (c_left_val),
			.right_val (c_right_val),
			.gt        (gt[i]),
			.val       (val[i])
		);
	end

	// count and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result item
	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q.occupancy <= count_ext[OCC_W-1:0];
			if (in_item.command == CMD_INSERT) begin
				out_item_q.status      <= is_full ? STATUS_FULL : STATUS_DONE;
				out_item_q.removed_job <= '0;
			end else begin
				out_item_q.status      <= is_empty ? STATUS_EMPTY : STATUS_DONE;
				out_item_q.removed_job <= is_empty ? '0 : val[0];
			end
		end
	end

endmodule

`default_nettype wire
